// ===== rtl/core/lru_key_value_cache_assert.svh =====
// Assertion macros used by the checker file
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// clocked property, masked while reset is asserted
`define LKV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset too
`define LKV_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lkv_pkg.sv =====
`default_nettype none
package lkv_pkg;

  // defaults for the top level parameters
  localparam int MAX_ENTRIES_DEF = 256;
  localparam int KEY_BITS_DEF    = 32;
  localparam int VALUE_BITS_DEF  = 64;

  // fixed field widths
  localparam int FUNC_W = 2;
  localparam int KEY_W  = 32;
  localparam int DATA_W = 64;
  localparam int OCC_W  = 9;
  localparam int CNT_W  = 32;
  localparam int CAP_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // stream widths and field positions
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 144;
  localparam int OUT_TUSER_W = 2;
  localparam int IN_KEY_LO   = 0;
  localparam int IN_DATA_LO  = 32;
  localparam int OD_DATA_LO  = 0;
  localparam int OD_OCC_LO   = 64;
  localparam int OD_HITS_LO  = 73;
  localparam int OD_MISS_LO  = 105;
  localparam int OD_USED_W   = 137;
  localparam int TU_HIT      = 0;
  localparam int TU_EVICT    = 1;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic upd;
    logic out_load;
  } lkv_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_search;
    logic need_update;
  } lkv_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/lru_key_value_cache.sv =====
// Channel  | Ports                        | Contents (low bits first)
// -------- | ---------------------------- | ------------------------------------------
// in       | in_tvalid/tready/tdata/tuser | tdata: key, data_in; tuser: func
// out      | out_tvalid/tready/tdata/tuser| tdata: data_out, occupancy, hit_total,
//          |                              |   miss_total; tuser: hit, evicted
// cfg      | cfg_we, cfg_wdata            | capacity
//
// Steps per accepted item:
// Lookup hit and insert: tag search sweep, then the recency rank read-modify-write
//   sweep, both one entry a cycle on one memory port.
// Lookup miss: tag search sweep only; clear and unused codes: no sweep.
// One item in flight; a new item is taken while the last result waits in the output reg.
// Reset empties the cache at once (valid bits in flops); no clearing pass.
// A stalled output holds the result and the next item finishes into the output reg later.
`default_nettype none
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // key[31:0], data_in[95:32]
  input  logic [FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // data_out, occupancy, hit_total, miss_total, pad
  output logic [OUT_TUSER_W-1:0] out_tuser,  // hit[0], evicted[1]
  input  logic                   cfg_we,
  input  logic [CAP_W-1:0]       cfg_wdata   // capacity
);

  lkv_cmd_t                       cmd;
  lkv_stat_t                      stat;
  logic [$clog2(MAX_ENTRIES)-1:0] addr;
  logic                           res_hit, res_evict;
  logic [DATA_W-1:0]              res_data;
  logic [OCC_W-1:0]               res_occ;
  logic [CNT_W-1:0]               res_hits, res_misses;

  lkv_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .addr       (addr),
    .stat       (stat)
  );

  lkv_dp #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .addr       (addr),
    .stat       (stat),
    .in_func    (func_t'(in_tuser)),
    .in_key     (in_tdata[IN_KEY_LO +: KEY_W]),
    .in_data    (in_tdata[IN_DATA_LO +: DATA_W]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_hit    (res_hit),
    .res_evict  (res_evict),
    .res_data   (res_data),
    .res_occ    (res_occ),
    .res_hits   (res_hits),
    .res_misses (res_misses)
  );

  // pack result item
  assign out_tdata = {{(OUT_TDATA_W - OD_USED_W){1'b0}}, res_misses, res_hits, res_occ,
                      res_data};
  assign out_tuser = {res_evict, res_hit};

endmodule
`default_nettype wire

// ===== rtl/core/lkv_ctrl.sv =====
`default_nettype none
module lkv_ctrl
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output lkv_cmd_t                       cmd,
  output logic [$clog2(MAX_ENTRIES)-1:0] addr,
  input  lkv_stat_t                      stat
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int SW = $clog2(MAX_ENTRIES + 2);
  localparam logic [SW-1:0] ISSUE_END = SW'(MAX_ENTRIES);
  localparam logic [SW-1:0] SCAN_END  = SW'(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_COMMIT,
    S_UPDATE,
    S_RESULT
  } state_t;

  state_t        state_r, state_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (!stat.need_search) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.scan = (cnt_r < ISSUE_END);
          cnt_nxt  = cnt_r + 1'b1;
          if (cnt_r == SCAN_END) begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = stat.need_update ? S_UPDATE : S_RESULT;
      end
      S_UPDATE: begin
        cmd.upd = (cnt_r < ISSUE_END);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ISSUE_END) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign addr       = cnt_r[AW-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/lkv_dp.sv =====
`default_nettype none
module lkv_dp
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lkv_cmd_t                       cmd,
  input  logic [$clog2(MAX_ENTRIES)-1:0] addr,
  output lkv_stat_t                      stat,
  input  func_t                          in_func,
  input  logic [KEY_W-1:0]               in_key,
  input  logic [DATA_W-1:0]              in_data,
  input  logic                           cfg_we,
  input  logic [CAP_W-1:0]               cfg_wdata,
  output logic                           res_hit,
  output logic                           res_evict,
  output logic [DATA_W-1:0]              res_data,
  output logic [OCC_W-1:0]               res_occ,
  output logic [CNT_W-1:0]               res_hits,
  output logic [CNT_W-1:0]               res_misses
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = (CW > CAP_W) ? CW : CAP_W;

  // entry storage
  logic [KEY_BITS-1:0]   key_mem  [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [MAX_ENTRIES];
  logic [AW-1:0]         rank_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;

  // latched item
  func_t                 func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [2*KEY_W-1:0]    key_wide;

  // control and counters
  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    count_r;
  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r;

  // read pipeline
  logic                  scan_d_r, upd_d_r;
  logic [AW-1:0]         idx_d_r;
  logic [KEY_BITS-1:0]   rd_key_r;
  logic [VALUE_BITS-1:0] rd_val_r;
  logic [AW-1:0]         rd_rank_r;

  // search results
  logic                  found_r, vic_ok_r, free_ok_r;
  logic [AW-1:0]         found_idx_r, found_rank_r, vic_idx_r, vic_rank_r, free_idx_r;
  logic [VALUE_BITS-1:0] found_val_r;

  // commit results
  logic          hit_r, evict_r, add_r;
  logic [AW-1:0] tgt_r;

  logic          rd_vld, match;
  logic          is_lookup, is_insert, full, do_evict, do_add;
  logic [EW-1:0] cap_ext, eff_cap;
  logic [AW-1:0] slot, tgt;
  logic [AW-1:0] rank_new;

  assign key_wide = {{KEY_W{1'b0}}, in_key};

  // compare stage
  assign rd_vld = valid_r[idx_d_r];
  assign match  = rd_vld && (rd_key_r == key_r);

  // effective capacity: zero acts as one, clamp to the store size
  always_comb begin
    cap_ext = EW'(cap_r);
    if (cap_r == '0) begin
      eff_cap = EW'(1);
    end else if (cap_ext > EW'(MAX_ENTRIES)) begin
      eff_cap = EW'(MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // commit decision
  assign is_lookup = (func_r == FUNC_LOOKUP);
  assign is_insert = (func_r == FUNC_INSERT);
  assign full      = (EW'(count_r) >= eff_cap);
  assign do_add    = is_insert && !found_r;
  assign do_evict  = do_add && full;
  assign slot      = (do_evict && (!free_ok_r || vic_idx_r < free_idx_r)) ? vic_idx_r
                                                                          : free_idx_r;
  assign tgt       = found_r ? found_idx_r : slot;

  assign stat.need_search = is_lookup || is_insert;
  assign stat.need_update = (found_r && (is_lookup || is_insert)) || do_add;

  // new rank during the update sweep
  always_comb begin
    if (idx_d_r == tgt_r) begin
      rank_new = '0;
    end else if (valid_r[idx_d_r] && (add_r || rd_rank_r < found_rank_r)) begin
      rank_new = rd_rank_r + AW'(1);
    end else begin
      rank_new = rd_rank_r;
    end
  end

  // memories: one read and one write a cycle
  always_ff @(posedge clk) begin
    rd_key_r  <= key_mem[addr];
    rd_val_r  <= val_mem[addr];
    rd_rank_r <= rank_mem[addr];
    if (cmd.commit && do_add) begin
      key_mem[tgt] <= key_r;
    end
    if (cmd.commit && is_insert) begin
      val_mem[tgt] <= val_r;
    end
    if (upd_d_r) begin
      rank_mem[idx_d_r] <= rank_new;
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= key_wide[KEY_BITS-1:0];
      val_r  <= in_data[VALUE_BITS-1:0];
    end
  end

  // pipeline flags and search tracking
  always_ff @(posedge clk) begin
    idx_d_r <= addr;
    if (!rst_n) begin
      scan_d_r  <= 1'b0;
      upd_d_r   <= 1'b0;
      found_r   <= 1'b0;
      vic_ok_r  <= 1'b0;
      free_ok_r <= 1'b0;
    end else begin
      scan_d_r <= cmd.scan;
      upd_d_r  <= cmd.upd;
      if (cmd.load) begin
        found_r   <= 1'b0;
        vic_ok_r  <= 1'b0;
        free_ok_r <= 1'b0;
      end else if (scan_d_r) begin
        if (match && !found_r) begin
          found_r      <= 1'b1;
          found_idx_r  <= idx_d_r;
          found_rank_r <= rd_rank_r;
          found_val_r  <= rd_val_r;
        end
        if (rd_vld && (!vic_ok_r || rd_rank_r > vic_rank_r)) begin
          vic_ok_r   <= 1'b1;
          vic_idx_r  <= idx_d_r;
          vic_rank_r <= rd_rank_r;
        end
        if (!rd_vld && !free_ok_r) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= idx_d_r;
        end
      end
    end
  end

  // commit: valid bits, occupancy, counters, capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      count_r    <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      cap_r      <= CAP_RESET;
      hit_r      <= 1'b0;
      evict_r    <= 1'b0;
      add_r      <= 1'b0;
      tgt_r      <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.commit) begin
        tgt_r <= tgt;
        add_r <= do_add;
        case (func_r)
          FUNC_LOOKUP: begin
            hit_r   <= found_r;
            evict_r <= 1'b0;
            if (found_r) begin
              if (hit_cnt_r != '1) hit_cnt_r <= hit_cnt_r + 1'b1;
            end else begin
              if (miss_cnt_r != '1) miss_cnt_r <= miss_cnt_r + 1'b1;
            end
          end
          FUNC_INSERT: begin
            hit_r   <= found_r;
            evict_r <= do_evict;
            if (do_add) begin
              if (do_evict) begin
                valid_r[vic_idx_r] <= 1'b0;
              end else begin
                count_r <= count_r + 1'b1;
              end
              valid_r[slot] <= 1'b1;
            end
          end
          FUNC_CLEAR: begin
            hit_r      <= 1'b0;
            evict_r    <= 1'b0;
            valid_r    <= '0;
            count_r    <= '0;
            hit_cnt_r  <= '0;
            miss_cnt_r <= '0;
          end
          default: begin
            hit_r   <= 1'b0;
            evict_r <= 1'b0;
          end
        endcase
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_hit    <= hit_r;
      res_evict  <= evict_r;
      res_data   <= (is_lookup && hit_r) ? DATA_W'(found_val_r) : '0;
      res_occ    <= OCC_W'(count_r);
      res_hits   <= hit_cnt_r;
      res_misses <= miss_cnt_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lkv_checker.sv =====
`default_nettype none
`include "lru_key_value_cache_assert.svh"
module lkv_checker
  import lkv_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  // stalled result item holds
  `LKV_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // no result right after reset
  `LKV_ASSERT_NORST(a_rst_quiet, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  // data is zero unless the item hit
  `LKV_ASSERT(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser[TU_HIT] |-> out_tdata[OD_DATA_LO +: DATA_W] == '0, "data on miss")

  // an eviction never comes with a hit
  `LKV_ASSERT(a_evict_miss, clk, rst_n, out_tvalid && out_tuser[TU_EVICT] |-> !out_tuser[TU_HIT], "evict on hit")

  // after an eviction the cache cannot be empty
  `LKV_ASSERT(a_evict_occ, clk, rst_n, out_tvalid && out_tuser[TU_EVICT] |-> out_tdata[OD_OCC_LO +: OCC_W] != '0, "evict left cache empty")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
